// ----- sv/pal_pkg.sv -----
// pal_pkg: shared widths, codes and cell interface structs for positional_array_list.
// Used by pal_cell and positional_array_list; no dependencies.
package pal_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef enum logic [1:0] {
    K_INSERT = 2'd0,
    K_REMOVE = 2'd1,
    K_READ   = 2'd2,
    K_SEARCH = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SH_HOLD = 2'd0,
    SH_INS  = 2'd1,
    SH_REM  = 2'd2
  } shift_op_t;

  // broadcast to every cell: shift the row around a 0-based slot
  typedef struct packed {
    shift_op_t                op;
    logic [IDX_W-1:0]         idx;
    logic signed [VAL_W-1:0]  value;
  } cell_cmd_t;

  // lookup token walking down the row, one cell per cycle
  typedef struct packed {
    logic                     valid;
    logic                     is_search;
    logic signed [VAL_W-1:0]  key;
    logic [IDX_W-1:0]         target;
    logic [CNT_W-1:0]         count;
    logic [CNT_W-1:0]         found;
    logic signed [VAL_W-1:0]  rd;
  } probe_t;

endpackage

// ----- sv/pal_cell.sv -----
// pal_cell: one list slot plus one stage of the lookup chain.
// Depends on pal_pkg.
module pal_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [pal_pkg::IDX_W-1:0]     cell_idx,
  input  pal_pkg::cell_cmd_t            cmd,
  input  logic signed [pal_pkg::VAL_W-1:0] left_val,
  input  logic signed [pal_pkg::VAL_W-1:0] right_val,
  output logic signed [pal_pkg::VAL_W-1:0] entry,
  input  pal_pkg::probe_t               probe_in,
  output pal_pkg::probe_t               probe_out
);

  logic signed [pal_pkg::VAL_W-1:0] entry_r;
  pal_pkg::probe_t                  probe_r;
  pal_pkg::probe_t                  probe_nxt;

  assign entry     = entry_r;
  assign probe_out = probe_r;

  // slots above the count hold don't-care data, so they shift freely
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      pal_pkg::SH_INS: begin
        if (cell_idx > cmd.idx) begin
          entry_r <= left_val;
        end else if (cell_idx == cmd.idx) begin
          entry_r <= cmd.value;
        end
      end
      pal_pkg::SH_REM: begin
        if (cell_idx >= cmd.idx) begin
          entry_r <= right_val;
        end
      end
      default: begin
        entry_r <= entry_r;
      end
    endcase
  end

  always_comb begin
    probe_nxt = probe_in;
    if (probe_in.valid) begin
      if (probe_in.is_search) begin
        if ((probe_in.found == '0) &&
            (pal_pkg::CNT_W'(cell_idx) < probe_in.count) &&
            (entry_r == probe_in.key)) begin
          probe_nxt.found = pal_pkg::CNT_W'(cell_idx) + pal_pkg::CNT_W'(1);
        end
      end else if (cell_idx == probe_in.target) begin
        probe_nxt.rd = entry_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.valid <= 1'b0;
    end else begin
      probe_r <= probe_nxt;
    end
  end

endmodule

// ----- sv/positional_array_list.sv -----
// positional_array_list: top level, row of pal_cell slots with count and result register.
// Depends on pal_pkg and pal_cell.
//
// Usage:
//   Requests enter on the in_ stream: in_tuser carries the kind (insert, remove,
//   read, search), in_tdata the 1-based position and the value. Each request
//   yields exactly one result on the out_ stream with status, found position,
//   read value and the length after the request.
//   Insert and remove shift every slot of the cell row at once; their result
//   is in the output register in the cycle after acceptance.
//   Read and search send a lookup token down the row, one cell per cycle; the
//   result is registered as the token leaves the last cell. Range and full
//   errors skip the walk and answer as insert and remove do.
//   One request is in flight at a time: in_tready is high only when no lookup
//   walks and the output register is empty, so a stalled receiver simply
//   holds off new requests while the result waits in out_tdata. Even with a
//   ready receiver, a new request is taken only after the previous result
//   has left the output register.
//   Reset (rst_n low, synchronous) empties the list and drops any pending
//   result; slot contents are not cleared, since only slots below the length
//   are ever read.
module positional_array_list (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [6:0] position, [38:7] value, [39] zero
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [1:0] status, [8:2] found_position,
                                  // [40:9] read_value, [47:41] length
);

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  state_t                            state_r;
  logic [pal_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic                              out_valid_r;
  pal_pkg::status_t                  out_status_r;
  logic [pal_pkg::POS_W-1:0]         out_found_r;
  logic signed [pal_pkg::VAL_W-1:0]  out_rd_r;
  logic [pal_pkg::POS_W-1:0]         out_len_r;

  logic                              accept;
  pal_pkg::kind_t                    kind;
  logic [pal_pkg::POS_W-1:0]         pos;
  logic signed [pal_pkg::VAL_W-1:0]  val;
  logic [pal_pkg::CMP_W-1:0]         pos_w, n_w;
  logic                              ins_ok, rr_ok, full;
  logic [pal_pkg::IDX_W-1:0]         slot;

  logic                              direct;    // answer now, no walk
  logic                              launch;    // start a lookup walk
  pal_pkg::status_t                  direct_status;
  pal_pkg::cell_cmd_t                cmd;
  pal_pkg::probe_t                   probe_launch;

  logic signed [pal_pkg::VAL_W-1:0]  ent   [pal_pkg::CAPACITY];
  pal_pkg::probe_t                   chain [pal_pkg::CAPACITY+1];
  pal_pkg::probe_t                   tail;
  logic [pal_pkg::CAPACITY-1:0]      chain_valid;

  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign accept     = in_tvalid && in_tready;
  assign kind       = pal_pkg::kind_t'(in_tuser);
  assign pos        = in_tdata[6:0];
  assign val        = in_tdata[38:7];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_len_r, out_rd_r, out_found_r, out_status_r};

  // position checks against the current length
  assign pos_w  = pal_pkg::CMP_W'(pos);
  assign n_w    = pal_pkg::CMP_W'(count_r);
  assign ins_ok = (pos_w != '0) && (pos_w <= n_w + pal_pkg::CMP_W'(1));
  assign rr_ok  = (pos_w != '0) && (pos_w <= n_w);
  assign full   = (count_r == pal_pkg::CNT_W'(pal_pkg::CAPACITY));
  assign slot   = pal_pkg::IDX_W'(pos_w - pal_pkg::CMP_W'(1));

  always_comb begin
    direct        = 1'b0;
    launch        = 1'b0;
    direct_status = pal_pkg::ST_OK;
    count_nxt     = count_r;
    cmd.op        = pal_pkg::SH_HOLD;
    cmd.idx       = slot;
    cmd.value     = val;
    if (accept) begin
      unique case (kind)
        pal_pkg::K_INSERT: begin
          direct = 1'b1;
          if (!ins_ok) begin
            direct_status = pal_pkg::ST_RANGE;
          end else if (full) begin
            direct_status = pal_pkg::ST_FULL;
          end else begin
            cmd.op    = pal_pkg::SH_INS;
            count_nxt = count_r + pal_pkg::CNT_W'(1);
          end
        end
        pal_pkg::K_REMOVE: begin
          direct = 1'b1;
          if (!rr_ok) begin
            direct_status = pal_pkg::ST_RANGE;
          end else begin
            cmd.op    = pal_pkg::SH_REM;
            count_nxt = count_r - pal_pkg::CNT_W'(1);
          end
        end
        pal_pkg::K_READ: begin
          if (!rr_ok) begin
            direct        = 1'b1;
            direct_status = pal_pkg::ST_RANGE;
          end else begin
            launch = 1'b1;
          end
        end
        pal_pkg::K_SEARCH: begin
          launch = 1'b1;
        end
        default: begin
          direct = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    probe_launch.valid     = launch;
    probe_launch.is_search = (kind == pal_pkg::K_SEARCH);
    probe_launch.key       = val;
    probe_launch.target    = slot;
    probe_launch.count     = count_r;
    probe_launch.found     = '0;
    probe_launch.rd        = '0;
  end

  assign chain[0] = probe_launch;
  assign tail     = chain[pal_pkg::CAPACITY];

  // cell row: neighbors feed inserts (from below) and removes (from above)
  for (genvar i = 0; i < pal_pkg::CAPACITY; i++) begin : g_cell
    logic signed [pal_pkg::VAL_W-1:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = ent[i-1];
    end
    if (i == pal_pkg::CAPACITY - 1) begin : g_last
      assign right_v = ent[i];
    end else begin : g_mid_r
      assign right_v = ent[i+1];
    end
    pal_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (pal_pkg::IDX_W'(i)),
      .cmd       (cmd),
      .left_val  (left_v),
      .right_val (right_v),
      .entry     (ent[i]),
      .probe_in  (chain[i]),
      .probe_out (chain[i+1])
    );
    assign chain_valid[i] = chain[i+1].valid;
  end

  // control and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (direct) begin
            out_valid_r  <= 1'b1;
            out_status_r <= direct_status;
            out_found_r  <= '0;
            out_rd_r     <= '0;
            out_len_r    <= pal_pkg::POS_W'(count_nxt);
          end else if (launch) begin
            state_r <= S_WALK;
          end
        end
        S_WALK: begin
          if (tail.valid) begin
            state_r      <= S_IDLE;
            out_valid_r  <= 1'b1;
            out_status_r <= pal_pkg::ST_OK;
            out_found_r  <= pal_pkg::POS_W'(tail.found);
            out_rd_r     <= tail.is_search ? '0 : tail.rd;
            out_len_r    <= pal_pkg::POS_W'(tail.count);
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // a new request never lands on a pending result
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !out_valid_r)
    else $error("request accepted while a result is pending");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= pal_pkg::CNT_W'(pal_pkg::CAPACITY))
    else $error("length exceeds capacity");

  a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(chain_valid))
    else $error("more than one lookup token in the cell row");

  a_tail_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid |-> (state_r == S_WALK))
    else $error("lookup token left the row outside a walk");

  a_count_stable_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |=> $stable(count_r))
    else $error("length changed during a lookup walk");

endmodule

// ----- verif/tb_positional_array_list.sv -----
// Testbench for positional_array_list: directed and random insert/remove/read/search
// requests checked against an in-bench list predictor. Depends on pal_pkg and the RTL.
`timescale 1ns / 100ps

module tb_positional_array_list;

  // Result fields as the block reports them for one request.
  typedef struct {
    pal_pkg::status_t   status;
    logic [6:0]         found_pos;
    logic signed [31:0] read_value;
    logic [6:0]         length;
  } list_result_t;

  localparam int RANDOM_ITEMS = 1500;
  localparam int POS_MAX      = 65;   // highest position the bench drives

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;    // [6:0] position, [38:7] value, [39] zero
  logic [1:0]  in_tuser;    // [1:0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;   // [1:0] status, [8:2] found_position,
                            // [40:9] read_value, [47:41] length

  // Shadow copy of the list contents, index 0 is position 1.
  logic signed [31:0] shadow_list[$];
  // Results predicted at acceptance, oldest first.
  list_result_t       pending_results[$];
  int                 fail_count = 0;

  positional_array_list i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // The slowest correct run, about 1600 requests each costing a lookup walk plus
  // sender gap plus receiver stall, ends well before this timeout.
  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: applies one accepted request to the shadow list and returns the
  // result the block must report. Range check comes before the full check, so
  // a bad insert position on a full list still reports a range error.
  // ---------------------------------------------------------------------------
  function automatic list_result_t apply_list_request(pal_pkg::kind_t kind, logic [6:0] pos,
                                                      logic signed [31:0] val);
    list_result_t r;
    int p;
    int n;
    p = int'(pos);
    n = shadow_list.size();
    r.status     = pal_pkg::ST_OK;
    r.found_pos  = '0;
    r.read_value = '0;
    case (kind)
      pal_pkg::K_INSERT: begin
        if (p < 1 || p > n + 1) r.status = pal_pkg::ST_RANGE;
        else if (n >= pal_pkg::CAPACITY) r.status = pal_pkg::ST_FULL;
        else shadow_list.insert(p - 1, val);
      end
      pal_pkg::K_REMOVE: begin
        if (p < 1 || p > n) r.status = pal_pkg::ST_RANGE;
        else shadow_list.delete(p - 1);
      end
      pal_pkg::K_READ: begin
        if (p < 1 || p > n) r.status = pal_pkg::ST_RANGE;
        else r.read_value = shadow_list[p - 1];
      end
      default: begin
        // search ignores the position; first match wins
        for (int i = 0; i < n; i++) begin
          if (shadow_list[i] == val) begin
            r.found_pos = 7'(i + 1);
            break;
          end
        end
      end
    endcase
    r.length = 7'(shadow_list.size());
    return r;
  endfunction

  // Drive one request and hold it until the block takes it. in_tvalid is left
  // high on return so back-to-back requests never drop it within one step.
  task automatic send_request(pal_pkg::kind_t kind, logic [6:0] pos,
                              logic signed [31:0] val);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {1'b0, val, pos};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_list_request(kind, pos, val));
  endtask

  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      in_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Hold off the sender until every outstanding request has been answered.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly legal positions for the kind at the current length; about one in
  // ten lands outside (0 or above the legal top, up to POS_MAX).
  function automatic logic [6:0] pick_position(pal_pkg::kind_t kind);
    int n;
    int top;
    n   = shadow_list.size();
    top = (kind == pal_pkg::K_INSERT) ? n + 1 : n;
    if (kind == pal_pkg::K_SEARCH) return 7'($urandom_range(0, POS_MAX));
    if (top >= 1 && $urandom_range(0, 9) != 0) return 7'($urandom_range(1, top));
    if (top + 1 > POS_MAX || $urandom_range(0, 2) == 0) return 7'd0;
    return 7'($urandom_range(top + 1, POS_MAX));
  endfunction

  // Search key: usually a value held in the list, sometimes anything.
  function automatic logic signed [31:0] pick_search_key();
    if (shadow_list.size() != 0 && $urandom_range(0, 9) < 7)
      return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
    return pick_value();
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: ready pattern switches among always-ready, random stalls, ready when
  // the two low tick bits are zero, and tick bit 3, each held for a random span.
  // ---------------------------------------------------------------------------
  int unsigned rx_tick = 0;
  int unsigned rx_span = 0;
  int unsigned rx_mode = 0;

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_span == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_span <= $urandom_range(16, 96);
    end else begin
      rx_span <= rx_span - 1;
    end
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      2:       out_tready <= (rx_tick[1:0] == 2'd0);
      default: out_tready <= rx_tick[3];
    endcase
  end

  // Result checker: values read here are the ones present at the edge.
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: %h", out_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[1:0] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_tdata[1:0]);
          fail_count++;
        end
        if (out_tdata[8:2] !== want.found_pos) begin
          $error("found_position: expected %0d, actual %0d", want.found_pos, out_tdata[8:2]);
          fail_count++;
        end
        if ($signed(out_tdata[40:9]) !== want.read_value) begin
          $error("read_value: expected %0d, actual %0d", want.read_value,
                 $signed(out_tdata[40:9]));
          fail_count++;
        end
        if (out_tdata[47:41] !== want.length) begin
          $error("length: expected %0d, actual %0d", want.length, out_tdata[47:41]);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every request on an empty list, then the first insert.
  task automatic test_empty_list();
    send_request(pal_pkg::K_READ,   7'd1,  32'sh1234_5678);   // nothing to read
    send_request(pal_pkg::K_REMOVE, 7'd1,  32'sd0);           // nothing to remove
    send_request(pal_pkg::K_SEARCH, 7'd0,  32'sd0);           // absent -> 0
    send_request(pal_pkg::K_INSERT, 7'd0,  32'sd5);           // position 0 never legal
    send_request(pal_pkg::K_INSERT, 7'd2,  32'sd5);           // past length + 1
    send_request(pal_pkg::K_INSERT, 7'd1,  32'sh7FFF_FFFF);
  endtask

  // Edges of the position range, value extremes, duplicates for search.
  task automatic test_positions();
    send_request(pal_pkg::K_INSERT, 7'd1,  32'sh8000_0000);   // at the front
    send_request(pal_pkg::K_INSERT, 7'd3,  32'sd0);           // append at length + 1
    send_request(pal_pkg::K_INSERT, 7'd2,  -32'sd1);          // middle
    send_request(pal_pkg::K_INSERT, 7'd6,  32'sd9);           // length + 2: range
    send_request(pal_pkg::K_INSERT, 7'd2,  32'sh7FFF_FFFF);   // duplicate of a later entry
    send_request(pal_pkg::K_READ,   7'd1,  32'shFFFF_FFFF);
    send_request(pal_pkg::K_READ,   7'd5,  32'sd0);
    send_request(pal_pkg::K_READ,   7'd0,  32'sd0);
    send_request(pal_pkg::K_READ,   7'd6,  32'sd0);
    send_request(pal_pkg::K_READ,   7'(POS_MAX), 32'sd0);
    send_request(pal_pkg::K_SEARCH, 7'd0,  32'sh7FFF_FFFF);   // first of two matches
    send_request(pal_pkg::K_SEARCH, 7'd3,  32'sd0);           // last entry
    send_request(pal_pkg::K_SEARCH, 7'(POS_MAX), 32'sd12345); // absent, position ignored
    send_request(pal_pkg::K_REMOVE, 7'd1,  32'sh5555_5555);   // front
    send_request(pal_pkg::K_REMOVE, 7'd4,  32'sd0);           // last
    send_request(pal_pkg::K_REMOVE, 7'd2,  32'sd0);           // middle
    send_request(pal_pkg::K_REMOVE, 7'd0,  32'sd0);
    send_request(pal_pkg::K_REMOVE, 7'd64, 32'sd0);
    // let the pipeline drain completely once before the next request
    wait_for_results();
    pause_sender($urandom_range(1, 5));
  endtask

  // Fill to capacity with random content, then probe the full-list cases.
  task automatic test_full_list();
    while (shadow_list.size() < pal_pkg::CAPACITY) begin
      send_request(pal_pkg::K_INSERT, 7'($urandom_range(1, shadow_list.size() + 1)),
                   pick_value());
      pause_sender($urandom_range(0, 1) ? 0 : $urandom_range(1, 4));
    end
    send_request(pal_pkg::K_INSERT, 7'(pal_pkg::CAPACITY + 1), 32'sd77);  // in range, full
    send_request(pal_pkg::K_INSERT, 7'd1,  32'sd77);                      // in range, full
    send_request(pal_pkg::K_INSERT, 7'd0,  32'sd77);                      // range wins over full
    send_request(pal_pkg::K_READ,   7'(pal_pkg::CAPACITY), 32'sd0);
    send_request(pal_pkg::K_READ,   7'(pal_pkg::CAPACITY + 1), 32'sd0);
    send_request(pal_pkg::K_SEARCH, 7'd0,  shadow_list[pal_pkg::CAPACITY - 1]);
    send_request(pal_pkg::K_REMOVE, 7'(pal_pkg::CAPACITY), 32'sd0);
    send_request(pal_pkg::K_INSERT, 7'(pal_pkg::CAPACITY), 32'sh8000_0000);
  endtask

  // Random request mix; the length drifts between empty and full so both
  // ends of the list are revisited many times.
  task automatic test_random_mix();
    bit              growing;
    int              roll;
    int              burst_left;
    pal_pkg::kind_t  kind;
    logic [6:0]      pos;
    logic signed [31:0] val;
    growing    = 1'b0;
    burst_left = 0;
    for (int item = 0; item < RANDOM_ITEMS; item++) begin
      if (shadow_list.size() == pal_pkg::CAPACITY) growing = 1'b0;
      else if (shadow_list.size() == 0) growing = 1'b1;
      else if ($urandom_range(0, 199) == 0) growing = ~growing;
      roll = $urandom_range(0, 99);
      if (growing) kind = (roll < 45) ? pal_pkg::K_INSERT : (roll < 60) ? pal_pkg::K_REMOVE :
                          (roll < 80) ? pal_pkg::K_READ : pal_pkg::K_SEARCH;
      else         kind = (roll < 15) ? pal_pkg::K_INSERT : (roll < 55) ? pal_pkg::K_REMOVE :
                          (roll < 78) ? pal_pkg::K_READ : pal_pkg::K_SEARCH;
      pos = pick_position(kind);
      val = (kind == pal_pkg::K_SEARCH) ? pick_search_key() : pick_value();
      send_request(kind, pos, val);
      // bursts with random gaps, except for a gapless stretch every 300
      if (item % 300 >= 60) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          pause_sender($urandom_range(1, 8));
        end else begin
          burst_left--;
        end
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = pal_pkg::K_INSERT;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_positions();
    test_full_list();
    test_random_mix();

    // all requests taken: wait for the answers, then idle past one more lookup
    // walk for anything unexpected to show up
    wait_for_results();
    repeat (pal_pkg::CAPACITY + 8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
